// File: hw/rtl/imufrp_pkg.sv
// shared types and constants for the imu frame record parser
package imufrp_pkg;

	localparam int WordW  = 32;
	localparam int NumWords = 9;
	localparam int MaskW  = 3;

	localparam logic [7:0]  Pre0Byte = 8'hFA;
	localparam logic [7:0]  Pre1Byte = 8'hFF;
	localparam logic [7:0]  Pre2Byte = 8'h36;
	localparam logic [15:0] IdEuler  = 16'h2030;
	localparam logic [15:0] IdAccel  = 16'h4020;
	localparam logic [15:0] IdRate   = 16'h8020;
	localparam logic [7:0]  VecSize  = 8'd12;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_PRE1    = 3'd1,
		PH_PRE2    = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		TGT_NONE  = 2'd0,
		TGT_EULER = 2'd1,
		TGT_ACCEL = 2'd2,
		TGT_RATE  = 2'd3
	} target_t;

	// nine stored words: euler xyz, accel xyz, rate xyz
	typedef logic [NumWords-1:0][WordW-1:0] word_vec_t;

	// status from the parser towards the stage control
	typedef struct packed {
		logic frame_end;
	} parse_status_t;

endpackage

// File: hw/rtl/imufrp_parse.sv
// per-byte frame parser: sync, record decode and stored sensor words
module imufrp_parse #(
	parameter int LENGTH_LIMIT = 250
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                rx_byte,
	output imufrp_pkg::parse_status_t status,
	output imufrp_pkg::word_vec_t     words,
	output logic [imufrp_pkg::MaskW-1:0] mask
);
	import imufrp_pkg::*;

	localparam logic [7:0] LenLimit = 8'(LENGTH_LIMIT);

	phase_t      phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  idx_q, idx_d;
	logic [15:0] id_q, id_d;
	logic [7:0]  size_q, size_d;
	target_t     tgt_q, tgt_d;
	logic        halt_q, halt_d;
	logic [23:0] wa_q, wa_d;
	logic [MaskW-1:0] flags_q, flags_d;
	logic [WordW-1:0] words_q [NumWords];

	logic        frame_end;
	logic        wr_en;
	logic [3:0]  wr_slot;
	logic [WordW-1:0] wr_word;
	logic [8:0]  rec_end;
	logic [7:0]  off;

	assign frame_end = (phase_q == PH_PAYLOAD) && (pos_q >= len_q);
	assign rec_end   = 9'({1'b0, pos_q}) + 9'd1 + 9'({1'b0, rx_byte});
	assign off       = idx_q - 8'd3;
	assign wr_word   = {wa_q, rx_byte};

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		pos_d   = pos_q;
		idx_d   = idx_q;
		id_d    = id_q;
		size_d  = size_q;
		tgt_d   = tgt_q;
		halt_d  = halt_q;
		wa_d    = wa_q;
		flags_d = flags_q;
		wr_en   = 1'b0;
		wr_slot = 4'd0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == Pre0Byte) phase_d = PH_PRE1;
			end
			PH_PRE1: phase_d = (rx_byte == Pre1Byte) ? PH_PRE2 : PH_HUNT;
			PH_PRE2: phase_d = (rx_byte == Pre2Byte) ? PH_LEN : PH_HUNT;
			PH_LEN: begin
				len_d   = rx_byte;
				pos_d   = 8'd0;
				idx_d   = 8'd0;
				id_d    = 16'd0;
				size_d  = 8'd0;
				tgt_d   = TGT_NONE;
				halt_d  = 1'b0;
				wa_d    = 24'd0;
				flags_d = '0;
				phase_d = (rx_byte != 8'd0 && rx_byte < LenLimit) ? PH_PAYLOAD : PH_HUNT;
			end
			PH_PAYLOAD: begin
				if (frame_end) begin
					phase_d = PH_HUNT;
				end else begin
					pos_d = pos_q + 8'd1;
					if (!halt_q) begin
						priority if (idx_q == 8'd0) begin
							id_d  = {rx_byte, 8'h00};
							idx_d = 8'd1;
						end else if (idx_q == 8'd1) begin
							id_d  = {id_q[15:8], rx_byte};
							idx_d = 8'd2;
						end else if (idx_q == 8'd2) begin
							size_d = rx_byte;
							tgt_d  = TGT_NONE;
							if (rec_end > 9'({1'b0, len_q})) begin
								halt_d = 1'b1;
							end else begin
								if (rx_byte == VecSize) begin
									priority if (id_q == IdEuler) tgt_d = TGT_EULER;
									else if (id_q == IdAccel) tgt_d = TGT_ACCEL;
									else if (id_q == IdRate)  tgt_d = TGT_RATE;
									else tgt_d = TGT_NONE;
								end
								wa_d  = 24'd0;
								idx_d = (rx_byte == 8'd0) ? 8'd0 : 8'd3;
							end
						end else begin
							// record content, words assembled big-endian
							wa_d = {wa_q[15:0], rx_byte};
							if (tgt_q != TGT_NONE && off[1:0] == 2'd3) begin
								wr_en = 1'b1;
								unique case (tgt_q)
									TGT_EULER: wr_slot = 4'd0 + 4'(off[3:2]);
									TGT_ACCEL: wr_slot = 4'd3 + 4'(off[3:2]);
									TGT_RATE:  wr_slot = 4'd6 + 4'(off[3:2]);
									default:   wr_slot = 4'd0;
								endcase
								flags_d = flags_q | MaskW'(1 << (tgt_q - 2'd1));
							end
							if (9'({1'b0, off}) + 9'd1 >= 9'({1'b0, size_q})) begin
								idx_d = 8'd0;
								tgt_d = TGT_NONE;
							end else begin
								idx_d = idx_q + 8'd1;
							end
						end
					end
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (step) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= 8'd0;
			pos_q   <= 8'd0;
			idx_q   <= 8'd0;
			id_q    <= 16'd0;
			size_q  <= 8'd0;
			tgt_q   <= TGT_NONE;
			halt_q  <= 1'b0;
			wa_q    <= 24'd0;
			flags_q <= '0;
		end else if (step) begin
			len_q   <= len_d;
			pos_q   <= pos_d;
			idx_q   <= idx_d;
			id_q    <= id_d;
			size_q  <= size_d;
			tgt_q   <= tgt_d;
			halt_q  <= halt_d;
			wa_q    <= wa_d;
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumWords; i++) words_q[i] <= '0;
		end else if (step && wr_en) begin
			words_q[wr_slot] <= wr_word;
		end
	end

	always_comb begin
		for (int i = 0; i < NumWords; i++) words[i] = words_q[i];
	end

	assign mask             = flags_q;
	assign status.frame_end = frame_end;

	a_bad_len_drops: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_LEN && rx_byte == 8'd0 |=> phase_q == PH_HUNT)
		else $error("zero length did not drop the frame");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pos_q <= len_q)
		else $error("payload position beyond frame length");

	a_content_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q > 8'd2 |-> !halt_q && size_q != 8'd0)
		else $error("record content in progress while parsing halted");

endmodule

// File: hw/rtl/imufrp_out_reg.sv
// result register holding one frame summary until taken
module imufrp_out_reg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  imufrp_pkg::word_vec_t            words_in,
	input  logic [imufrp_pkg::MaskW-1:0]     mask_in,
	output logic                             can_load,
	output logic                             out_valid,
	input  logic                             out_ready,
	output imufrp_pkg::word_vec_t            words_out,
	output logic [imufrp_pkg::MaskW-1:0]     mask_out
);
	import imufrp_pkg::*;

	logic      valid_q;
	word_vec_t words_q;
	logic [MaskW-1:0] mask_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			words_q <= words_in;
			mask_q  <= mask_in;
		end
	end

	assign out_valid = valid_q;
	assign words_out = words_q;
	assign mask_out  = mask_q;

endmodule

// File: hw/rtl/imu_frame_record_parser_core.sv
// top level of the imu frame record parser: input register, parser, result register
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+--------------------------------------------
// input   | in        | in_valid / in_ready  | rx_byte
// result  | out       | out_valid / out_ready| euler_xyz, accel_xyz, rate_xyz, updated_mask
//
// one byte per cycle unless stalled; a byte is registered, then decoded in the next cycle
// the trailing byte loads the result register when it steps, out_valid with it
// input stalls only when a trailing byte meets a full result register that is not drained
// asynchronous active-low reset clears sync state, stored words and the valid flags
module imu_frame_record_parser_core #(
	parameter int LENGTH_LIMIT = 250
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] euler_x,
	output logic [31:0] euler_y,
	output logic [31:0] euler_z,
	output logic [31:0] accel_x,
	output logic [31:0] accel_y,
	output logic [31:0] accel_z,
	output logic [31:0] rate_x,
	output logic [31:0] rate_y,
	output logic [31:0] rate_z,
	output logic [2:0]  updated_mask
);
	import imufrp_pkg::*;

	// input register stage
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// stage control
	logic          step;
	logic          can_load;
	parse_status_t status;
	word_vec_t     words;
	word_vec_t     words_out;
	logic [MaskW-1:0] mask;

	// a buffered byte moves on unless it ends a frame and the result slot is busy
	assign step     = valid_s1 && (!status.frame_end || can_load);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	imufrp_parse #(
		.LENGTH_LIMIT(LENGTH_LIMIT)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.status  (status),
		.words   (words),
		.mask    (mask)
	);

	// the trailing byte publishes the words as they stand before it
	imufrp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && status.frame_end),
		.words_in  (words),
		.mask_in   (mask),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.words_out (words_out),
		.mask_out  (updated_mask)
	);

	assign euler_x = words_out[0];
	assign euler_y = words_out[1];
	assign euler_z = words_out[2];
	assign accel_x = words_out[3];
	assign accel_y = words_out[4];
	assign accel_z = words_out[5];
	assign rate_x  = words_out[6];
	assign rate_y  = words_out[7];
	assign rate_z  = words_out[8];

	a_end_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && status.frame_end |=> out_valid)
		else $error("frame end did not load the result register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_ready |-> status.frame_end && out_valid && !out_ready)
		else $error("input stalled without a blocked frame end");

	a_halted_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		step && !status.frame_end |=> !out_valid || $past(out_valid && !out_ready))
		else $error("result appeared without a frame end");

endmodule

// File: tb/tb_imu_frame_record_parser_core.sv
// self-checking testbench for the imu frame record parser core
`timescale 1ns / 1ps

module tb_imu_frame_record_parser_core;
	import imufrp_pkg::*;

	localparam int LengthLimit = 250;
	// cycles with no handshake on either side before the run is declared hung
	localparam int HangLimit   = 500;
	// cycles allowed after the last result for anything stray to show up
	localparam int SettleCycles = 20;
	localparam int RoundItems  = 825;

	// what one frame end reports: nine stored words plus the update mask
	typedef struct packed {
		word_vec_t        words;
		logic [MaskW-1:0] mask;
	} frame_report_t;

	// one row of the directed table: a byte and, where obvious, the report it ends with
	typedef struct packed {
		logic [7:0]    rx;
		logic          typed;
		frame_report_t report;
	} dir_row_t;

	localparam frame_report_t ALL_CLEAR = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] euler_x, euler_y, euler_z;
	logic [31:0] accel_x, accel_y, accel_z;
	logic [31:0] rate_x, rate_y, rate_z;
	logic [2:0]  updated_mask;

	imu_frame_record_parser_core #(
		.LENGTH_LIMIT(LengthLimit)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.euler_x     (euler_x),
		.euler_y     (euler_y),
		.euler_z     (euler_z),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.rate_x      (rate_x),
		.rate_y      (rate_y),
		.rate_z      (rate_z),
		.updated_mask(updated_mask)
	);

	always #5 clk = ~clk;

	// reports still owed by the block, oldest first
	frame_report_t pending_frames[$];
	// random bytes waiting to be sent
	logic [7:0]    byte_backlog[$];
	int            mismatches = 0;
	bit            src_steady = 1'b0;
	bit            sink_steady = 1'b0;

	string word_name [NumWords] = '{"euler_x", "euler_y", "euler_z",
		"accel_x", "accel_y", "accel_z", "rate_x", "rate_y", "rate_z"};

	// parser model state, cleared as the block is by reset
	phase_t      pr_phase = PH_HUNT;
	logic [7:0]  pr_len = 8'd0;
	logic [7:0]  pr_pos = 8'd0;
	logic [7:0]  pr_idx = 8'd0;
	logic [15:0] pr_id = 16'd0;
	logic [7:0]  pr_size = 8'd0;
	target_t     pr_tgt = TGT_NONE;
	logic        pr_halt = 1'b0;
	logic [31:0] pr_acc = 32'd0;
	word_vec_t   pr_words = '0;
	logic [2:0]  pr_flags = 3'd0;

	// directed part: preamble faults, length extremes, the shortest frame
	dir_row_t dir_tab [24] = '{
		// zero length drops the frame
		'{8'hFA, 1'b0, ALL_CLEAR}, '{8'hFF, 1'b0, ALL_CLEAR},
		'{8'h36, 1'b0, ALL_CLEAR}, '{8'h00, 1'b0, ALL_CLEAR},
		// length at the limit drops it too
		'{8'hFA, 1'b0, ALL_CLEAR}, '{8'hFF, 1'b0, ALL_CLEAR},
		'{8'h36, 1'b0, ALL_CLEAR}, '{8'hFA, 1'b0, ALL_CLEAR},
		// wrong second preamble byte
		'{8'hFA, 1'b0, ALL_CLEAR}, '{8'h00, 1'b0, ALL_CLEAR},
		// wrong third preamble byte
		'{8'hFA, 1'b0, ALL_CLEAR}, '{8'hFF, 1'b0, ALL_CLEAR}, '{8'h00, 1'b0, ALL_CLEAR},
		// second FA is the mismatch and is not taken as a fresh start
		'{8'hFA, 1'b0, ALL_CLEAR}, '{8'hFA, 1'b0, ALL_CLEAR}, '{8'hFF, 1'b0, ALL_CLEAR},
		'{8'h36, 1'b0, ALL_CLEAR}, '{8'h01, 1'b0, ALL_CLEAR},
		// one-byte payload, header never completes; nothing stored since reset
		'{8'hFA, 1'b0, ALL_CLEAR}, '{8'hFF, 1'b0, ALL_CLEAR}, '{8'h36, 1'b0, ALL_CLEAR},
		'{8'h01, 1'b0, ALL_CLEAR}, '{8'h00, 1'b0, ALL_CLEAR}, '{8'h55, 1'b1, ALL_CLEAR}
	};

	// advance the parser model by one byte; have is set on a frame end
	task automatic parse_byte(input logic [7:0] b, output bit have, output frame_report_t rep);
		int off;
		int slot;
		have = 1'b0;
		rep = ALL_CLEAR;
		case (pr_phase)
		PH_HUNT: begin
			if (b == Pre0Byte)
				pr_phase = PH_PRE1;
		end
		PH_PRE1: pr_phase = (b == Pre1Byte) ? PH_PRE2 : PH_HUNT;
		PH_PRE2: pr_phase = (b == Pre2Byte) ? PH_LEN : PH_HUNT;
		PH_LEN: begin
			pr_len = b;
			pr_pos = 8'd0;
			pr_idx = 8'd0;
			pr_id = 16'd0;
			pr_size = 8'd0;
			pr_tgt = TGT_NONE;
			pr_halt = 1'b0;
			pr_acc = 32'd0;
			pr_flags = 3'd0;
			pr_phase = (b != 8'd0 && int'(b) < LengthLimit) ? PH_PAYLOAD : PH_HUNT;
		end
		PH_PAYLOAD: begin
			if (pr_pos >= pr_len) begin
				// trailing byte, unchecked, closes the frame
				have = 1'b1;
				rep.words = pr_words;
				rep.mask = pr_flags;
				pr_phase = PH_HUNT;
			end else begin
				if (!pr_halt) begin
					if (pr_idx == 8'd0) begin
						pr_id = {b, 8'h00};
						pr_idx = 8'd1;
					end else if (pr_idx == 8'd1) begin
						pr_id[7:0] = b;
						pr_idx = 8'd2;
					end else if (pr_idx == 8'd2) begin
						pr_size = b;
						pr_tgt = TGT_NONE;
						if (int'(pr_pos) + 1 + int'(b) > int'(pr_len)) begin
							// record runs past the length: stop for this frame
							pr_halt = 1'b1;
						end else begin
							if (b == VecSize) begin
								case (pr_id)
								IdEuler: pr_tgt = TGT_EULER;
								IdAccel: pr_tgt = TGT_ACCEL;
								IdRate:  pr_tgt = TGT_RATE;
								default: pr_tgt = TGT_NONE;
								endcase
							end
							pr_acc = 32'd0;
							pr_idx = (b == 8'd0) ? 8'd0 : 8'd3;
						end
					end else begin
						off = int'(pr_idx) - 3;
						pr_acc = {pr_acc[23:0], b};
						if (pr_tgt != TGT_NONE && off[1:0] == 2'd3) begin
							slot = (int'(pr_tgt) - 1) * 3 + (off >> 2);
							if (slot < NumWords) begin
								pr_words[slot] = pr_acc;
								pr_flags[int'(pr_tgt) - 1] = 1'b1;
							end
						end
						if (off + 1 >= int'(pr_size)) begin
							pr_idx = 8'd0;
							pr_tgt = TGT_NONE;
						end else begin
							pr_idx = pr_idx + 8'd1;
						end
					end
				end
				pr_pos = pr_pos + 8'd1;
			end
		end
		default: pr_phase = PH_HUNT;
		endcase
	endtask

	// offer one item after a random gap, wait for it to be taken, then predict
	task automatic push_byte(input logic [7:0] b, input logic typed, input frame_report_t fixed);
		int gap;
		bit have;
		frame_report_t rep;
		if ($urandom_range(0, 49) == 0)
			src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		parse_byte(b, have, rep);
		if (have)
			pending_frames.push_back(typed ? fixed : rep);
	endtask

	// sender holds off until every owed report has come out
	task automatic drain_reports();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_id(input logic [15:0] id);
		byte_backlog.push_back(id[15:8]);
		byte_backlog.push_back(id[7:0]);
	endtask

	// append one random frame, broken preamble or run of noise to the backlog
	task automatic add_frame();
		int kind;
		int target_len;
		int len;
		int sel;
		int size;
		logic [15:0] id;
		logic [7:0] body[$];
		kind = $urandom_range(0, 19);
		if (kind < 2) begin
			// line noise, sometimes with stray FA bytes
			repeat ($urandom_range(1, 6))
				byte_backlog.push_back(($urandom_range(0, 3) == 0) ? Pre0Byte : 8'($urandom));
		end else if (kind < 4) begin
			// preamble broken after one or two bytes
			byte_backlog.push_back(Pre0Byte);
			if ($urandom_range(0, 1))
				byte_backlog.push_back(Pre1Byte);
			byte_backlog.push_back(8'($urandom));
		end else if (kind == 4) begin
			// length out of range
			byte_backlog.push_back(Pre0Byte);
			byte_backlog.push_back(Pre1Byte);
			byte_backlog.push_back(Pre2Byte);
			byte_backlog.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(250, 255)));
		end else begin
			// proper frame, mostly short, now and then the longest allowed
			target_len = ($urandom_range(0, 39) == 0) ? LengthLimit - 1 : $urandom_range(1, 48);
			while (body.size() < target_len) begin
				sel = $urandom_range(0, 9);
				if (sel < 7) begin
					case (sel % 3)
					0: id = IdEuler;
					1: id = IdAccel;
					default: id = IdRate;
					endcase
					size = (sel < 6) ? int'(VecSize) : $urandom_range(0, 20);
				end else begin
					id = 16'($urandom);
					case (sel)
					7: size = $urandom_range(0, 16);
					8: size = 0;
					default: size = $urandom_range(0, 255);
					endcase
				end
				body.push_back(id[15:8]);
				body.push_back(id[7:0]);
				body.push_back(8'(size));
				repeat (size)
					body.push_back(8'($urandom));
			end
			// either the records fill the length exactly or the last one is cut
			if ($urandom_range(0, 1) && body.size() < LengthLimit)
				len = body.size();
			else
				len = target_len;
			while (body.size() > len)
				void'(body.pop_back());
			byte_backlog.push_back(Pre0Byte);
			byte_backlog.push_back(Pre1Byte);
			byte_backlog.push_back(Pre2Byte);
			byte_backlog.push_back(8'(len));
			foreach (body[i])
				byte_backlog.push_back(body[i]);
			byte_backlog.push_back(8'($urandom));
		end
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected %h got %h", $realtime, what, want, got);
	endtask

	// result side: random back-pressure and field-by-field comparison
	always @(posedge clk or negedge arst_n) begin : sink_side
		frame_report_t want;
		word_vec_t     seen;
		int            hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold = 0;
		end else if (out_valid && out_ready) begin
			seen = {rate_z, rate_y, rate_x, accel_z, accel_y, accel_x, euler_z, euler_y, euler_x};
			if (pending_frames.size() == 0) begin
				note_mismatch("report with none owed", 32'd0, {29'd0, updated_mask});
			end else begin
				want = pending_frames.pop_front();
				for (int k = 0; k < NumWords; k++) begin
					if (seen[k] !== want.words[k])
						note_mismatch(word_name[k], want.words[k], seen[k]);
				end
				if (updated_mask !== want.mask)
					note_mismatch("updated_mask", {29'd0, want.mask}, {29'd0, updated_mask});
			end
			if ($urandom_range(0, 19) == 0)
				sink_steady = !sink_steady;
			hold = sink_steady ? 0 : $urandom_range(0, 8);
			out_ready <= (hold == 0);
		end else if (!out_ready) begin
			if (hold <= 1)
				out_ready <= 1'b1;
			hold = hold - 1;
		end
	end

	// hang detector: too long without any handshake
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < HangLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("imu_frame_record_parser_core: mismatch");
		$finish;
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			push_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].report);
		drain_reports();

		// two random rounds with a full drain between them
		repeat (2) begin
			while (byte_backlog.size() < RoundItems)
				add_frame();
			while (byte_backlog.size() != 0)
				push_byte(byte_backlog.pop_front(), 1'b0, ALL_CLEAR);
			drain_reports();
		end

		repeat (SettleCycles) @(posedge clk);
		if (pending_frames.size() != 0)
			note_mismatch("reports never delivered", 32'd0, pending_frames.size());

		if (mismatches == 0)
			$display("imu_frame_record_parser_core: match");
		else
			$display("imu_frame_record_parser_core: mismatch");
		$finish;
	end

endmodule
